FILE: rtl/bscs_pkg.sv
package bscs_pkg;

  // default data format
  localparam int FRAC_BITS_DEF   = 8;
  localparam int COORD_WIDTH_DEF = 24;

  // register widths
  localparam int SCREEN_W = 13;
  localparam int MARGIN_W = 12;
  localparam int LIMIT_W  = 20;
  localparam int TURN_W   = 16;
  localparam int DT_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // register reset values
  localparam logic [SCREEN_W-1:0] SCREEN_W_RST = 13'd800;
  localparam logic [SCREEN_W-1:0] SCREEN_H_RST = 13'd800;
  localparam logic [MARGIN_W-1:0] MARGIN_RST   = 12'd100;
  localparam logic [LIMIT_W-1:0]  MIN_SPD_RST  = 20'd25600;
  localparam logic [LIMIT_W-1:0]  MAX_SPD_RST  = 20'd76800;
  localparam logic [TURN_W-1:0]   TURN_RST     = 16'd2560;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 3'd0,
    CFG_SCREEN_HEIGHT = 3'd1,
    CFG_EDGE_MARGIN   = 3'd2,
    CFG_MIN_SPEED     = 3'd3,
    CFG_MAX_SPEED     = 3'd4,
    CFG_TURN_AMOUNT   = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CLAMP_NONE  = 2'd0,
    CLAMP_RAISE = 2'd1,
    CLAMP_LOWER = 2'd2
  } clamp_t;

endpackage

FILE: rtl/bscs_sqrt_cell.sv
// One digit of the square root: takes two radicand bits, yields one root bit.
module bscs_sqrt_cell #(
  parameter int W  = bscs_pkg::COORD_WIDTH_DEF,
  parameter int PW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_i,
  input  logic [2*W-1:0]  s_i,
  input  logic [W+2:0]    rem_i,
  input  logic [W-1:0]    root_i,
  input  logic [PW-1:0]   pass_i,
  output logic            vld_o,
  output logic [2*W-1:0]  s_o,
  output logic [W+2:0]    rem_o,
  output logic [W-1:0]    root_o,
  output logic [PW-1:0]   pass_o
);

  logic [W+2:0] rem_sh;
  logic [W+2:0] trial;
  logic         ge;
  logic [W+2:0] rem_nxt;

  // bring in the next bit pair and try the subtraction
  always_comb begin
    rem_sh  = {rem_i[W:0], s_i[2*W-1:2*W-2]};
    trial   = (W+3)'({root_i, 2'b01});
    ge      = (rem_sh >= trial);
    rem_nxt = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  // advance the digit state
  always_ff @(posedge clk) begin
    if (en) begin
      s_o    <= {s_i[2*W-3:0], 2'b00};
      rem_o  <= rem_nxt;
      root_o <= {root_i[W-2:0], ge};
      pass_o <= pass_i;
    end
  end

endmodule

FILE: rtl/bscs_div_cell.sv
// One quotient bit of a restoring division, for both axes against one divisor.
module bscs_div_cell #(
  parameter int W  = bscs_pkg::COORD_WIDTH_DEF,
  parameter int PW = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                vld_i,
  input  logic [W:0]                          d_i,
  input  logic [1:0][W+1:0]                   rem_i,
  input  logic [1:0][bscs_pkg::LIMIT_W-1:0]   nlo_i,
  input  logic [1:0][bscs_pkg::LIMIT_W-1:0]   q_i,
  input  logic [PW-1:0]                       pass_i,
  output logic                                vld_o,
  output logic [W:0]                          d_o,
  output logic [1:0][W+1:0]                   rem_o,
  output logic [1:0][bscs_pkg::LIMIT_W-1:0]   nlo_o,
  output logic [1:0][bscs_pkg::LIMIT_W-1:0]   q_o,
  output logic [PW-1:0]                       pass_o
);

  localparam int LW = bscs_pkg::LIMIT_W;

  logic [1:0][W+1:0] rem_sh;
  logic [1:0]        ge;
  logic [1:0][W+1:0] rem_nxt;

  // shift in one numerator bit per lane and subtract where it fits
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rem_sh[i]  = {rem_i[i][W:0], nlo_i[i][LW-1]};
      ge[i]      = (rem_sh[i] >= {1'b0, d_i});
      rem_nxt[i] = ge[i] ? (rem_sh[i] - {1'b0, d_i}) : rem_sh[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_o    <= d_i;
      pass_o <= pass_i;
      for (int i = 0; i < 2; i++) begin
        rem_o[i] <= rem_nxt[i];
        nlo_o[i] <= {nlo_i[i][LW-2:0], 1'b0};
        q_o[i]   <= {q_i[i][LW-2:0], ge[i]};
      end
    end
  end

endmodule

FILE: rtl/boid_speed_clamp_edge_steer_step.sv
// Speed limit and edge steering for one flocking particle per word. The block
// takes one word per clock while the output is not held back and returns one
// result per word, in order. A word passes COORD_WIDTH + 28 register stages.
// The stages are a chain of COORD_WIDTH square-root cells (one root bit each),
// a chain of 20 divider cells (one quotient bit each, both axes side by side)
// and a few multiply and compare stages around them. When the output word is
// held back, the whole chain holds and in_ready drops. Configuration writes
// are taken at any cycle and are meant to be made while no word is in flight.
module boid_speed_clamp_edge_steer_step #(
  parameter int FRAC_BITS   = bscs_pkg::FRAC_BITS_DEF,
  parameter int COORD_WIDTH = bscs_pkg::COORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [bscs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bscs_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COORD_WIDTH-1:0]         in_pos_x,
  input  logic signed [COORD_WIDTH-1:0]         in_pos_y,
  input  logic signed [COORD_WIDTH-1:0]         in_vel_x,
  input  logic signed [COORD_WIDTH-1:0]         in_vel_y,
  input  logic [bscs_pkg::DT_W-1:0]             in_time_step,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [COORD_WIDTH-1:0]         out_new_pos_x,
  output logic signed [COORD_WIDTH-1:0]         out_new_pos_y,
  output logic signed [COORD_WIDTH-1:0]         out_new_vel_x,
  output logic signed [COORD_WIDTH-1:0]         out_new_vel_y,
  output logic [1:0]                            out_clamp_status
);

  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int LW  = bscs_pkg::LIMIT_W;
  localparam int DW  = bscs_pkg::DT_W;
  localparam int SW  = 2 * W + 1;
  localparam int CW  = (SW > 2 * LW) ? SW : 2 * LW;
  localparam int X0  = (W + 2 > LW + 3) ? W + 2 : LW + 3;
  localparam int XW  = (X0 > 15 + F) ? X0 : 15 + F;
  localparam int NW  = W + LW + 1;
  localparam int PW  = 4 * W + DW + 2 + LW;
  localparam logic signed [XW-1:0] VMAX = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] VMIN = ~VMAX;

  function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] v);
    if (v > VMAX) return VMAX[W-1:0];
    if (v < VMIN) return VMIN[W-1:0];
    return v[W-1:0];
  endfunction

  function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  logic en;
  logic out_valid_r;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;

  // configuration registers
  logic [bscs_pkg::SCREEN_W-1:0] scr_w_r, scr_h_r;
  logic [bscs_pkg::MARGIN_W-1:0] margin_r;
  logic [LW-1:0]                 min_spd_r, max_spd_r;
  logic [bscs_pkg::TURN_W-1:0]   turn_r;
  logic [2*LW-1:0]               min_sq_r, max_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r   <= bscs_pkg::SCREEN_W_RST;
      scr_h_r   <= bscs_pkg::SCREEN_H_RST;
      margin_r  <= bscs_pkg::MARGIN_RST;
      min_spd_r <= bscs_pkg::MIN_SPD_RST;
      max_spd_r <= bscs_pkg::MAX_SPD_RST;
      turn_r    <= bscs_pkg::TURN_RST;
    end else if (cfg_we) begin
      case (bscs_pkg::cfg_idx_t'(cfg_index))
        bscs_pkg::CFG_SCREEN_WIDTH:  scr_w_r   <= cfg_wdata[bscs_pkg::SCREEN_W-1:0];
        bscs_pkg::CFG_SCREEN_HEIGHT: scr_h_r   <= cfg_wdata[bscs_pkg::SCREEN_W-1:0];
        bscs_pkg::CFG_EDGE_MARGIN:   margin_r  <= cfg_wdata[bscs_pkg::MARGIN_W-1:0];
        bscs_pkg::CFG_MIN_SPEED:     min_spd_r <= cfg_wdata[LW-1:0];
        bscs_pkg::CFG_MAX_SPEED:     max_spd_r <= cfg_wdata[LW-1:0];
        bscs_pkg::CFG_TURN_AMOUNT:   turn_r    <= cfg_wdata[bscs_pkg::TURN_W-1:0];
        default: ;
      endcase
    end
  end

  // squared limits, settled well before the next word
  always_ff @(posedge clk) begin
    min_sq_r <= min_spd_r * min_spd_r;
    max_sq_r <= max_spd_r * max_spd_r;
  end

  // stage A: capture and square the velocity magnitudes
  logic                   a_vld_r;
  logic signed [W-1:0]    a_px_r, a_py_r, a_vx_r, a_vy_r;
  logic [DW-1:0]          a_dt_r;
  logic [2*W-1:0]         a_sqx_r, a_sqy_r;
  logic [W-1:0]           in_mx, in_my;

  assign in_mx = mag_w(in_vel_x);
  assign in_my = mag_w(in_vel_y);

  // stage B: sum of squares
  logic                   b_vld_r;
  logic signed [W-1:0]    b_px_r, b_py_r, b_vx_r, b_vy_r;
  logic [DW-1:0]          b_dt_r;
  logic [SW-1:0]          b_s_r;

  // stage C: band test
  logic                   c_vld_r;
  logic [PW-1:0]          c_pass_r;
  logic [SW-1:0]          c_s_r;
  logic [1:0]             b_status;
  logic [LW-1:0]          b_limit;

  always_comb begin
    b_status = bscs_pkg::CLAMP_NONE;
    b_limit  = min_spd_r;
    if (b_s_r != '0) begin
      if (CW'(b_s_r) < CW'(min_sq_r)) begin
        b_status = bscs_pkg::CLAMP_RAISE;
        b_limit  = min_spd_r;
      end else if (CW'(b_s_r) > CW'(max_sq_r)) begin
        b_status = bscs_pkg::CLAMP_LOWER;
        b_limit  = max_spd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_px_r   <= in_pos_x;
      a_py_r   <= in_pos_y;
      a_vx_r   <= in_vel_x;
      a_vy_r   <= in_vel_y;
      a_dt_r   <= in_time_step;
      a_sqx_r  <= in_mx * in_mx;
      a_sqy_r  <= in_my * in_my;
      b_px_r   <= a_px_r;
      b_py_r   <= a_py_r;
      b_vx_r   <= a_vx_r;
      b_vy_r   <= a_vy_r;
      b_dt_r   <= a_dt_r;
      b_s_r    <= SW'(a_sqx_r) + SW'(a_sqy_r);
      c_s_r    <= b_s_r;
      c_pass_r <= {b_px_r, b_py_r, b_vx_r, b_vy_r, b_dt_r, b_status, b_limit};
    end
  end

  // square-root chain, one root bit per cell
  logic [W:0]       sq_vld;
  logic [2*W-1:0]   sq_s    [0:W];
  logic [W+2:0]     sq_rem  [0:W];
  logic [W-1:0]     sq_root [0:W];
  logic [PW-1:0]    sq_pass [0:W];

  assign sq_vld[0]  = c_vld_r;
  assign sq_s[0]    = c_s_r[2*W-1:0];
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_pass[0] = c_pass_r;

  for (genvar k = 0; k < W; k++) begin : g_sqrt
    bscs_sqrt_cell #(.W(W), .PW(PW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (sq_vld[k]),
      .s_i    (sq_s[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .pass_i (sq_pass[k]),
      .vld_o  (sq_vld[k+1]),
      .s_o    (sq_s[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .pass_o (sq_pass[k+1])
    );
  end

  // stage M: scale magnitudes by the limit
  logic signed [W-1:0] sq_vx, sq_vy;
  logic [LW-1:0]       sq_limit;
  logic                m_vld_r;
  logic [W+LW-1:0]     m_prodx_r, m_prody_r;
  logic [W-1:0]        m_sp_r;
  logic [PW-1:0]       m_pass_r;

  assign sq_vx    = sq_pass[W][2*W+DW+2+LW-1 -: W];
  assign sq_vy    = sq_pass[W][W+DW+2+LW-1 -: W];
  assign sq_limit = sq_pass[W][LW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= sq_vld[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_prodx_r <= mag_w(sq_vx) * sq_limit;
      m_prody_r <= mag_w(sq_vy) * sq_limit;
      m_sp_r    <= sq_root[W];
      m_pass_r  <= sq_pass[W];
    end
  end

  // rounding numerators: 2*|v|*limit + sp over 2*sp
  logic [NW-1:0] num_x, num_y;

  assign num_x = {m_prodx_r, 1'b0} + NW'(m_sp_r);
  assign num_y = {m_prody_r, 1'b0} + NW'(m_sp_r);

  // divider chain, one quotient bit per cell
  logic [LW:0]               dv_vld;
  logic [W:0]                dv_d    [0:LW];
  logic [1:0][W+1:0]         dv_rem  [0:LW];
  logic [1:0][LW-1:0]        dv_nlo  [0:LW];
  logic [1:0][LW-1:0]        dv_q    [0:LW];
  logic [PW-1:0]             dv_pass [0:LW];

  assign dv_vld[0]     = m_vld_r;
  assign dv_d[0]       = {m_sp_r, 1'b0};
  assign dv_rem[0][0]  = (W+2)'(num_x[NW-1:LW]);
  assign dv_rem[0][1]  = (W+2)'(num_y[NW-1:LW]);
  assign dv_nlo[0][0]  = num_x[LW-1:0];
  assign dv_nlo[0][1]  = num_y[LW-1:0];
  assign dv_q[0]       = '0;
  assign dv_pass[0]    = m_pass_r;

  for (genvar k = 0; k < LW; k++) begin : g_div
    bscs_div_cell #(.W(W), .PW(PW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (dv_vld[k]),
      .d_i    (dv_d[k]),
      .rem_i  (dv_rem[k]),
      .nlo_i  (dv_nlo[k]),
      .q_i    (dv_q[k]),
      .pass_i (dv_pass[k]),
      .vld_o  (dv_vld[k+1]),
      .d_o    (dv_d[k+1]),
      .rem_o  (dv_rem[k+1]),
      .nlo_o  (dv_nlo[k+1]),
      .q_o    (dv_q[k+1]),
      .pass_o (dv_pass[k+1])
    );
  end

  // unpack the words leaving the divider
  logic signed [W-1:0] dv_px, dv_py, dv_vx, dv_vy;
  logic [DW-1:0]       dv_dt;
  logic [1:0]          dv_status;
  logic [LW-1:0]       dv_limit;

  assign {dv_px, dv_py, dv_vx, dv_vy, dv_dt, dv_status, dv_limit} = dv_pass[LW];

  // stage F1: pick the rescaled or the original velocity
  logic signed [XW-1:0] qx_w, qy_w;
  logic signed [W-1:0]  f1_vx_nxt, f1_vy_nxt;

  always_comb begin
    qx_w = XW'(dv_q[LW][0]);
    qy_w = XW'(dv_q[LW][1]);
    f1_vx_nxt = dv_vx;
    f1_vy_nxt = dv_vy;
    if (dv_status != bscs_pkg::CLAMP_NONE) begin
      f1_vx_nxt = sat_w(dv_vx[W-1] ? -qx_w : qx_w);
      f1_vy_nxt = sat_w(dv_vy[W-1] ? -qy_w : qy_w);
    end
  end

  logic                f1_vld_r;
  logic signed [W-1:0] f1_px_r, f1_py_r, f1_vx_r, f1_vy_r;
  logic [DW-1:0]       f1_dt_r;
  logic [1:0]          f1_status_r;

  // stage F2: steer away from the screen edges
  logic signed [XW-1:0] lo_b, hix_b, hiy_b, turn_w;
  logic signed [XW-1:0] f1_pxw, f1_pyw, f1_vxw, f1_vyw;
  logic signed [W-1:0]  f2_vx_nxt, f2_vy_nxt;

  always_comb begin
    lo_b   = XW'({1'b0, margin_r}) <<< F;
    hix_b  = XW'($signed({1'b0, scr_w_r}) - $signed({2'b00, margin_r})) <<< F;
    hiy_b  = XW'($signed({1'b0, scr_h_r}) - $signed({2'b00, margin_r})) <<< F;
    turn_w = XW'(turn_r);
    f1_pxw = XW'(f1_px_r);
    f1_pyw = XW'(f1_py_r);
    f1_vxw = XW'(f1_vx_r);
    f1_vyw = XW'(f1_vy_r);
    f2_vx_nxt = f1_vx_r;
    f2_vy_nxt = f1_vy_r;
    if (f1_pxw < lo_b)  f2_vx_nxt = sat_w(f1_vxw + turn_w);
    if (f1_pxw > hix_b) f2_vx_nxt = sat_w(f1_vxw - turn_w);
    if (f1_pyw < lo_b)  f2_vy_nxt = sat_w(f1_vyw + turn_w);
    if (f1_pyw > hiy_b) f2_vy_nxt = sat_w(f1_vyw - turn_w);
  end

  logic                f2_vld_r;
  logic signed [W-1:0] f2_px_r, f2_py_r, f2_vx_r, f2_vy_r;
  logic [DW-1:0]       f2_dt_r;
  logic [1:0]          f2_status_r;

  // stage F3: distance magnitudes over the time step
  logic                f3_vld_r;
  logic signed [W-1:0] f3_px_r, f3_py_r, f3_vx_r, f3_vy_r;
  logic [W+DW-1:0]     f3_dx_r, f3_dy_r;
  logic [1:0]          f3_status_r;

  // stage F4: round, apply sign, add to the position
  logic [W+DW:0]        rnd_x, rnd_y;
  logic signed [XW-1:0] mx_w, my_w;

  always_comb begin
    rnd_x = (W+DW+1)'(f3_dx_r) + (W+DW+1)'(1 << (DW - 1));
    rnd_y = (W+DW+1)'(f3_dy_r) + (W+DW+1)'(1 << (DW - 1));
    mx_w  = XW'(rnd_x[W+DW:DW]);
    my_w  = XW'(rnd_y[W+DW:DW]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r    <= 1'b0;
      f2_vld_r    <= 1'b0;
      f3_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      f1_vld_r    <= dv_vld[LW];
      f2_vld_r    <= f1_vld_r;
      f3_vld_r    <= f2_vld_r;
      out_valid_r <= f3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_px_r     <= dv_px;
      f1_py_r     <= dv_py;
      f1_vx_r     <= f1_vx_nxt;
      f1_vy_r     <= f1_vy_nxt;
      f1_dt_r     <= dv_dt;
      f1_status_r <= dv_status;
      f2_px_r     <= f1_px_r;
      f2_py_r     <= f1_py_r;
      f2_vx_r     <= f2_vx_nxt;
      f2_vy_r     <= f2_vy_nxt;
      f2_dt_r     <= f1_dt_r;
      f2_status_r <= f1_status_r;
      f3_px_r     <= f2_px_r;
      f3_py_r     <= f2_py_r;
      f3_vx_r     <= f2_vx_r;
      f3_vy_r     <= f2_vy_r;
      f3_dx_r     <= mag_w(f2_vx_r) * f2_dt_r;
      f3_dy_r     <= mag_w(f2_vy_r) * f2_dt_r;
      f3_status_r <= f2_status_r;
      out_new_pos_x    <= sat_w(XW'(f3_px_r) + (f3_vx_r[W-1] ? -mx_w : mx_w));
      out_new_pos_y    <= sat_w(XW'(f3_py_r) + (f3_vy_r[W-1] ? -my_w : my_w));
      out_new_vel_x    <= f3_vx_r;
      out_new_vel_y    <= f3_vy_r;
      out_clamp_status <= f3_status_r;
    end
  end

endmodule

FILE: rtl/bscs_checker.sv
// Port-level checks on the result channel and the stall path.
module bscs_checker #(
  parameter int COORD_WIDTH = bscs_pkg::COORD_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [COORD_WIDTH-1:0] out_new_pos_x,
  input logic signed [COORD_WIDTH-1:0] out_new_vel_x,
  input logic [1:0]                    out_clamp_status
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_new_pos_x) && $stable(out_new_vel_x)
      && $stable(out_clamp_status))
    else $error("stalled result word changed");

  // input side stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a held result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_clamp_status != 2'd3)
    else $error("undefined clamp status");

endmodule

bind boid_speed_clamp_edge_steer_step bscs_checker #(.COORD_WIDTH(COORD_WIDTH)) u_bscs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_new_pos_x    (out_new_pos_x),
  .out_new_vel_x    (out_new_vel_x),
  .out_clamp_status (out_clamp_status)
);

FILE: test/tb_boid_speed_clamp_edge_steer_step.sv
`timescale 1ns / 100ps

module tb_boid_speed_clamp_edge_steer_step;

  localparam int CW = 24;
  localparam int FB = 8;
  localparam int LATENCY = CW + 28;
  localparam longint MAX_CYCLES = 400000;

  typedef struct packed {
    logic signed [CW-1:0]       pos_x;
    logic signed [CW-1:0]       pos_y;
    logic signed [CW-1:0]       vel_x;
    logic signed [CW-1:0]       vel_y;
    logic [bscs_pkg::DT_W-1:0]  time_step;
  } particle_t;

  typedef struct packed {
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] vel_x;
    logic signed [CW-1:0] vel_y;
    bscs_pkg::clamp_t     status;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [bscs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bscs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] in_pos_x = '0, in_pos_y = '0, in_vel_x = '0, in_vel_y = '0;
  logic [bscs_pkg::DT_W-1:0] in_time_step = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CW-1:0] out_new_pos_x, out_new_pos_y, out_new_vel_x, out_new_vel_y;
  logic [1:0] out_clamp_status;

  boid_speed_clamp_edge_steer_step dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor copy of the registers
  longint scr_w, scr_h, margin, spd_min, spd_max, turn;

  particle_t pending_words[$];
  step_t     expected_steps[$];
  int        fail_count = 0;
  int        sent_count = 0;
  int        recv_count = 0;
  int        raise_count = 0;
  int        lower_count = 0;
  longint    cycle_count = 0;
  bit        long_hold = 1'b0;

  function automatic longint clip(longint v);
    longint hi;
    hi = (64'sd1 <<< (CW - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint int_sqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint scale_axis(longint v, longint lim, longint sp);
    longint unsigned m, q;
    m = (v < 0) ? -v : v;
    q = (m * lim * 2 + sp) / (2 * sp);
    return clip(v < 0 ? -longint'(q) : longint'(q));
  endfunction

  function automatic longint steer_axis(longint p, longint v, longint scr);
    longint lo, hi, r;
    lo = margin <<< FB;
    hi = (scr - margin) * (64'sd1 <<< FB);
    r = v;
    if (p < lo) r = clip(v + turn);
    if (p > hi) r = clip(v - turn);
    return r;
  endfunction

  function automatic longint move_axis(longint p, longint v, longint dt);
    longint unsigned m;
    longint d;
    m = (v < 0) ? -v : v;
    d = longint'((m * dt + (64'd1 << 15)) >> 16);
    return clip(p + (v < 0 ? -d : d));
  endfunction

  function automatic step_t predict_step(particle_t w);
    step_t r;
    longint px, py, vx, vy, sp, lim;
    longint unsigned s;
    bscs_pkg::clamp_t st;
    px = w.pos_x; py = w.pos_y; vx = w.vel_x; vy = w.vel_y;
    s = vx * vx + vy * vy;
    st = bscs_pkg::CLAMP_NONE;
    lim = 0;
    if (s != 0) begin
      if (s < spd_min * spd_min) begin
        st = bscs_pkg::CLAMP_RAISE; lim = spd_min;
      end else if (s > spd_max * spd_max) begin
        st = bscs_pkg::CLAMP_LOWER; lim = spd_max;
      end
      if (st != bscs_pkg::CLAMP_NONE) begin
        sp = int_sqrt(s);
        vx = scale_axis(vx, lim, sp);
        vy = scale_axis(vy, lim, sp);
      end
    end
    vx = steer_axis(px, vx, scr_w);
    vy = steer_axis(py, vy, scr_h);
    r.pos_x = CW'(move_axis(px, vx, w.time_step));
    r.pos_y = CW'(move_axis(py, vy, w.time_step));
    r.vel_x = CW'(vx);
    r.vel_y = CW'(vy);
    r.status = st;
    return r;
  endfunction

  // driver: offer queued words with random gaps
  int send_gap = 0;
  always @(posedge clk) begin
    particle_t w;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_steps.push_back(predict_step(pending_words.pop_front()));
        sent_count++;
        send_gap = $urandom_range(0, 6);
      end
      if (!in_valid || in_ready) begin
        if (send_gap == 0 && pending_words.size() != 0) begin
          w = pending_words[0];
          in_valid <= 1'b1;
          in_pos_x <= w.pos_x;
          in_pos_y <= w.pos_y;
          in_vel_x <= w.vel_x;
          in_vel_y <= w.vel_y;
          in_time_step <= w.time_step;
        end else begin
          in_valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end
      end
    end
  end

  // long hold-off once so the pipeline fills and stalls the input
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (long_hold && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 3 * LATENCY;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: check each result word against the oldest prediction
  int recv_gap = 0;
  always @(posedge clk) begin
    step_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        recv_count++;
        if (expected_steps.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          e = expected_steps.pop_front();
          if (out_new_pos_x !== e.pos_x) begin
            $error("new_pos_x exp %0d got %0d", e.pos_x, out_new_pos_x); fail_count++;
          end
          if (out_new_pos_y !== e.pos_y) begin
            $error("new_pos_y exp %0d got %0d", e.pos_y, out_new_pos_y); fail_count++;
          end
          if (out_new_vel_x !== e.vel_x) begin
            $error("new_vel_x exp %0d got %0d", e.vel_x, out_new_vel_x); fail_count++;
          end
          if (out_new_vel_y !== e.vel_y) begin
            $error("new_vel_y exp %0d got %0d", e.vel_y, out_new_vel_y); fail_count++;
          end
          if (out_clamp_status !== e.status) begin
            $error("clamp_status exp %0d got %0d", e.status, out_clamp_status);
            fail_count++;
          end
          if (e.status == bscs_pkg::CLAMP_RAISE) raise_count++;
          if (e.status == bscs_pkg::CLAMP_LOWER) lower_count++;
        end
        recv_gap = $urandom_range(0, 6);
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(bscs_pkg::cfg_idx_t idx, longint val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= bscs_pkg::CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bscs_pkg::CFG_SCREEN_WIDTH:  scr_w = val & 13'h1FFF;
      bscs_pkg::CFG_SCREEN_HEIGHT: scr_h = val & 13'h1FFF;
      bscs_pkg::CFG_EDGE_MARGIN:   margin = val & 12'hFFF;
      bscs_pkg::CFG_MIN_SPEED:     spd_min = val & 20'hFFFFF;
      bscs_pkg::CFG_MAX_SPEED:     spd_max = val & 20'hFFFFF;
      bscs_pkg::CFG_TURN_AMOUNT:   turn = val & 16'hFFFF;
      default: ;
    endcase
  endtask

  task automatic set_regs(longint w, longint h, longint m, longint mn, longint mx,
                          longint t);
    write_reg(bscs_pkg::CFG_SCREEN_WIDTH, w);
    write_reg(bscs_pkg::CFG_SCREEN_HEIGHT, h);
    write_reg(bscs_pkg::CFG_EDGE_MARGIN, m);
    write_reg(bscs_pkg::CFG_MIN_SPEED, mn);
    write_reg(bscs_pkg::CFG_MAX_SPEED, mx);
    write_reg(bscs_pkg::CFG_TURN_AMOUNT, t);
  endtask

  task automatic drain;
    wait (pending_words.size() == 0 && !in_valid && expected_steps.size() == 0);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic queue_word(longint px, longint py, longint vx, longint vy, longint dt);
    particle_t w;
    w.pos_x = CW'(px);
    w.pos_y = CW'(py);
    w.vel_x = CW'(vx);
    w.vel_y = CW'(vy);
    w.time_step = bscs_pkg::DT_W'(dt);
    pending_words.push_back(w);
  endtask

  function automatic longint rand_coord();
    case ($urandom_range(0, 3))
      0: return $signed(24'($urandom));
      1: return longint'($urandom_range(0, 2000 << FB)) - 200 * 256;
      2: return $urandom_range(0, 1) ? 8388607 : -8388608;
      default: return longint'($urandom_range(0, 1200 << FB));
    endcase
  endfunction

  function automatic longint rand_vel();
    case ($urandom_range(0, 3))
      0: return $signed(24'($urandom));
      1: return longint'($urandom_range(0, 200000)) - 100000;
      2: return longint'($urandom_range(0, 8)) - 4;
      default: return longint'($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  task automatic random_words(int n);
    repeat (n) queue_word(rand_coord(), rand_coord(), rand_vel(), rand_vel(),
                          $urandom_range(0, 1) ? $urandom_range(0, 65535) : 16'hFFFF);
  endtask

  initial begin
    scr_w = bscs_pkg::SCREEN_W_RST; scr_h = bscs_pkg::SCREEN_H_RST;
    margin = bscs_pkg::MARGIN_RST;
    spd_min = bscs_pkg::MIN_SPD_RST; spd_max = bscs_pkg::MAX_SPD_RST;
    turn = bscs_pkg::TURN_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero, extremes, raise, lower, both edges
    queue_word(0, 0, 0, 0, 16'hFFFF);
    queue_word(8388607, 8388607, 8388607, 8388607, 16'hFFFF);
    queue_word(-8388608, -8388608, -8388608, -8388608, 16'hFFFF);
    queue_word(400 << FB, 400 << FB, 1, 0, 1000);
    queue_word(400 << FB, 400 << FB, 1000, -1000, 0);
    queue_word(400 << FB, 400 << FB, 200000, 3, 32768);
    queue_word(10 << FB, 790 << FB, 30000, 30000, 40000);
    queue_word(100 << FB, 700 << FB, 0, -30000, 40000);
    queue_word(-5, 701 << FB, -40000, 40000, 65535);
    queue_word(8388607, -8388608, 8388607, -8388608, 65535);
    drain();

    // extreme settings: margin wider than screen, max below min
    set_regs(1, 1, 2048, 1048575, 0, 65535);
    queue_word(0, 0, 3, -4, 65535);
    queue_word(8388607, -8388608, 8388607, 8388607, 65535);
    queue_word(-8388608, 8388607, 0, 0, 65535);
    random_words(150);
    drain();

    set_regs(4096, 4096, 0, 0, 1048575, 0);
    random_words(150);
    drain();

    set_regs(640, 480, 40, 500, 300000, 300);
    random_words(50);
    long_hold = 1'b1;
    random_words(200);
    drain();

    set_regs(8191, 2000, 4095, 1000, 2000, 256);
    random_words(150);
    drain();

    set_regs(800, 800, 100, 25600, 76800, 2560);
    random_words(330);
    drain();

    $display("Ran %0d particle words over six register settings: %0d raised, %0d lowered.",
             sent_count, raise_count, lower_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
